// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition checked every clock, disabled in reset
`define ASSERT_ALW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`endif

// File: rtl/core/mlht_pkg.sv
// Package for the multilevel hash table: constants, status and op codes, hash helpers.
package mlht_pkg;

    localparam int INIT_SLOTS_DEF = 64;
    localparam int MAX_LEVELS_DEF = 6;

    localparam logic [1:0] ST_ABSENT   = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'h85ebca6b;
    localparam logic [31:0] C4 = 32'hc2b2ae35;
    localparam logic [31:0] CADD = 32'he6546b64;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: rtl/core/multilevel_hash_table.sv
// Multilevel two-way hash table of 64-bit keys, top level.
//  channel   dir  ports                        transfer
//  command   in   start, op, key               start && !busy
//  result    out  done, status, levels_in_use  done (one cycle)
//  config    in   cfg_we, cfg_data             cfg_we
// After reset a clearing pass walks the valid memory, one slot a cycle over all
// INIT_SLOTS*(2^MAX_LEVELS-1) slots (4032 by default), with busy high.
// An item runs the hash steps H0 to H4, then per level visited a read and way 0,
// plus way 1 unless way 0 is empty or hits, then finish and a return to idle; one
// shared 32x32 multiplier and the single-port memories keep these steps in series.
// The receiver cannot stall; done pulses once per command.
module multilevel_hash_table
    import mlht_pkg::*;
#(
    parameter int INIT_SLOTS = INIT_SLOTS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] key,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  levels_in_use,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);
    `include "assert_macros.svh"

    localparam int TOTAL = INIT_SLOTS * ((1 << MAX_LEVELS) - 1);
    localparam int AW    = $clog2(TOTAL);
    localparam int LW    = $clog2(MAX_LEVELS + 1);
    localparam int SW    = $clog2(INIT_SLOTS);

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_H0   = 11'b00000000100,
        S_H1   = 11'b00000001000,
        S_H2   = 11'b00000010000,
        S_H3   = 11'b00000100000,
        S_H4   = 11'b00001000000,
        S_RD   = 11'b00010000000,
        S_W0   = 11'b00100000000,
        S_W1   = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0]   seed_reg;
    logic          op_reg;
    logic [63:0]   key_reg;
    logic [31:0]   h_reg;
    logic [LW-1:0] lvl_reg;
    logic [LW-1:0] act_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] base_reg;
    logic          grow_reg;
    logic [1:0]    st_reg;

    // shared multiplier
    logic [31:0] ma, mb, mp;
    assign mp = ma * mb;

    logic [31:0] hmix, h16;
    assign hmix = seed_reg ^ mp;
    assign h16  = h_reg ^ (h_reg >> 16);

    always_comb
    begin
        ma = h16;
        mb = C3;
        case (state_reg)
            S_H0:    begin ma = key_reg[31:0]; mb = C1; end
            S_H1:    begin ma = h_reg; mb = C2; end
            S_H2:    begin ma = h_reg; mb = 32'd5; end
            S_H3:    begin ma = h16; mb = C3; end
            S_H4:    begin ma = h_reg ^ (h_reg >> 13); mb = C4; end
            default: begin ma = h16; mb = C3; end
        endcase
    end

    // bucket base of level lvl: INIT_SLOTS*(2^lvl-1) + 2*(hash mod (INIT_SLOTS<<lvl)/2)
    function automatic logic [AW-1:0] base_of(input logic [31:0] h, input logic [LW-1:0] l);
        logic [AW:0] off;
        logic [AW:0] msk;
        off = (AW+1)'(INIT_SLOTS) * (((AW+1)'(1) << l) - (AW+1)'(1));
        msk = (((AW+1)'(INIT_SLOTS) << l) >> 1) - (AW+1)'(1);
        base_of = AW'(off + (((AW+1)'(h) & msk) << 1));
    endfunction

    logic        vram_we, vram_wd, vram_rd;
    logic        kram_we;
    logic [63:0] kram_rd;
    logic [AW-1:0] ram_addr;

    mlht_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_valid (
        .clk(clk), .we(vram_we), .addr(ram_addr), .wdata(vram_wd), .rdata(vram_rd)
    );
    mlht_ram #(.WIDTH(64), .DEPTH(TOTAL)) u_key (
        .clk(clk), .we(kram_we), .addr(ram_addr), .wdata(key_reg), .rdata(kram_rd)
    );

    logic way_hit;
    assign way_hit = vram_rd && (kram_rd == key_reg);

    always_comb
    begin
        state_next = state_reg;
        vram_we  = 1'b0;
        vram_wd  = 1'b0;
        kram_we  = 1'b0;
        ram_addr = addr_reg;
        case (state_reg)
            S_CLR:
            begin
                vram_we = 1'b1;
                if (addr_reg == AW'(TOTAL - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:  if (start) state_next = S_H0;
            S_H0:    state_next = S_H1;
            S_H1:    state_next = S_H2;
            S_H2:    state_next = S_H3;
            S_H3:    state_next = S_H4;
            S_H4:    state_next = S_RD;
            S_RD:    state_next = S_W0;
            S_W0:
            begin
                // way 0 data present; issue way 1 read
                ram_addr = base_reg + AW'(1);
                if (!vram_rd || way_hit)
                    state_next = S_FIN;
                else
                    state_next = S_W1;
            end
            S_W1:
            begin
                if (!vram_rd || way_hit || lvl_reg + LW'(1) >= act_reg)
                    state_next = S_FIN;
                else
                    state_next = S_RD;
            end
            S_FIN:
            begin
                if (grow_reg)
                begin
                    vram_we = 1'b1;
                    vram_wd = 1'b1;
                    kram_we = 1'b1;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            seed_reg  <= '0;
            act_reg   <= LW'(1);
            addr_reg  <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            if (cfg_we)
                seed_reg <= cfg_data;
            case (state_reg)
                S_CLR: addr_reg <= addr_reg + AW'(1);
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= op;
                        key_reg <= key;
                        grow_reg <= 1'b0;
                    end
                end
                S_H0: h_reg <= rotl32(mp, 15);
                S_H1: h_reg <= rotl32(hmix, 13);
                S_H2: h_reg <= (mp + CADD) ^ 32'd4;
                S_H3: h_reg <= mp;
                S_H4:
                begin
                    h_reg    <= mp ^ (mp >> 16);
                    lvl_reg  <= '0;
                    base_reg <= base_of(mp ^ (mp >> 16), '0);
                    addr_reg <= base_of(mp ^ (mp >> 16), '0);
                end
                S_RD: ;
                S_W0:
                begin
                    if (!vram_rd)
                    begin
                        grow_reg <= (op_reg == OP_INSERT);
                        st_reg   <= (op_reg == OP_INSERT) ? ST_INSERTED : ST_ABSENT;
                    end
                    else if (way_hit)
                    begin
                        st_reg  <= (op_reg == OP_INSERT) ? ST_ABSENT : ST_FOUND;
                    end
                    else
                        addr_reg <= base_reg + AW'(1);
                end
                S_W1:
                begin
                    if (!vram_rd)
                    begin
                        grow_reg <= (op_reg == OP_INSERT);
                        st_reg   <= (op_reg == OP_INSERT) ? ST_INSERTED : ST_ABSENT;
                    end
                    else if (way_hit)
                    begin
                        st_reg  <= (op_reg == OP_INSERT) ? ST_ABSENT : ST_FOUND;
                    end
                    else if (lvl_reg + LW'(1) >= act_reg)
                    begin
                        // every enabled level full
                        if (op_reg == OP_QUERY)
                            st_reg <= ST_ABSENT;
                        else if (act_reg >= LW'(MAX_LEVELS))
                            st_reg <= ST_FULL;
                        else
                        begin
                            st_reg   <= ST_INSERTED;
                            grow_reg <= 1'b1;
                            act_reg  <= act_reg + LW'(1);
                            addr_reg <= base_of(h_reg, act_reg);
                        end
                    end
                    else
                    begin
                        lvl_reg  <= lvl_reg + LW'(1);
                        base_reg <= base_of(h_reg, lvl_reg + LW'(1));
                        addr_reg <= base_of(h_reg, lvl_reg + LW'(1));
                    end
                end
                S_FIN: done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign status = st_reg;
    assign levels_in_use = 3'(act_reg);

    `ASSERT_IMP(a_done_after_fin, clk, rst_n, done, $past(state_reg) == S_FIN, "done without finish")
    `ASSERT_ALW(a_levels_range, clk, rst_n, act_reg >= LW'(1) && act_reg <= LW'(MAX_LEVELS), "levels out of range")
    `ASSERT_IMP(a_grow_insert, clk, rst_n, state_reg == S_FIN && grow_reg, op_reg == OP_INSERT, "write on query")
    `ASSERT_IMP(a_busy_start, clk, rst_n, state_reg == S_IDLE && start, ##1 busy, "start not taken")
endmodule

// File: rtl/core/mlht_ram.sv
// Generic single-port RAM with registered read.
module mlht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4032
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: tb/tb_multilevel_hash_table.sv
// Testbench for the multilevel hash table: directed and random inserts and queries.
module tb_multilevel_hash_table;
    import mlht_pkg::*;

    typedef struct {
        logic        op;
        logic [63:0] key;
    } cmd_t;

    typedef struct {
        logic [1:0] status;
        logic [2:0] levels;
    } res_t;

    localparam int N_SLOTS = 64 * 63;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] key;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  levels_in_use;
    logic        cfg_we;
    logic [31:0] cfg_data;

    multilevel_hash_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .key(key),
        .done(done),
        .status(status),
        .levels_in_use(levels_in_use),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    cmd_t        pending_cmds[$];
    res_t        result_q[$];
    logic [63:0] key_pool[$];
    int          n_errors = 0;
    bit          idle_on = 1;
    bit          took;
    int          gap = 0;

    // shadow of the table
    logic [31:0] seed_sh;
    logic [63:0] slot_key_sh[N_SLOTS];
    bit          slot_valid_sh[N_SLOTS];
    int          levels_sh;

    function automatic logic [31:0] rol(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] bucket_hash(logic [31:0] k, logic [31:0] s);
        logic [31:0] h;
        h = s;
        k = k * 32'hcc9e2d51;
        k = rol(k, 15);
        k = k * 32'h1b873593;
        h = h ^ k;
        h = rol(h, 13);
        h = h * 32'd5 + 32'he6546b64;
        h = h ^ 32'd4;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int way0_index(logic [31:0] h, int lvl);
        longint unsigned half;
        half = 64'd32 << lvl;
        return 64 * ((1 << lvl) - 1) + int'(longint'({32'd0, h} % half) * 2);
    endfunction

    function automatic res_t table_apply(cmd_t c);
        logic [31:0] h;
        int          idx;
        bit          hit;
        res_t        r;
        h = bucket_hash(c.key[31:0], seed_sh);
        hit = 0;
        r.status = ST_ABSENT;
        for (int lvl = 0; lvl < levels_sh && !hit; lvl++)
        begin
            for (int w = 0; w < 2 && !hit; w++)
            begin
                idx = way0_index(h, lvl) + w;
                if (!slot_valid_sh[idx])
                begin
                    if (c.op == OP_INSERT)
                    begin
                        slot_valid_sh[idx] = 1;
                        slot_key_sh[idx] = c.key;
                        r.status = ST_INSERTED;
                    end
                    hit = 1;
                end
                else if (slot_key_sh[idx] == c.key)
                begin
                    r.status = (c.op == OP_INSERT) ? ST_ABSENT : ST_FOUND;
                    hit = 1;
                end
            end
        end
        if (!hit && c.op == OP_INSERT)
        begin
            if (levels_sh >= 6)
                r.status = ST_FULL;
            else
            begin
                // grow: new level is empty, key lands in way 0
                idx = way0_index(h, levels_sh);
                levels_sh++;
                slot_valid_sh[idx] = 1;
                slot_key_sh[idx] = c.key;
                r.status = ST_INSERTED;
            end
        end
        r.levels = levels_sh[2:0];
        return r;
    endfunction

    task automatic report(string what);
        n_errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 0;
        else if (start && !took)
            start <= 1;
        else if (gap > 0)
        begin
            start <= 0;
            gap--;
        end
        else if (pending_cmds.size() > 0)
        begin
            cmd_t c;
            c = pending_cmds.pop_front();
            start <= 1;
            op <= c.op;
            key <= c.key;
            if (idle_on && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 18);
        end
        else
            start <= 0;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        res_t want;
        cmd_t c;
        if (rst_n)
        begin
            took <= start && !busy;
            if (cfg_we)
                seed_sh = cfg_data;
            if (start && !busy)
            begin
                c.op = op;
                c.key = key;
                result_q.push_back(table_apply(c));
            end
            if (done)
            begin
                if (result_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                        report($sformatf("status %0d, want %0d", status, want.status));
                    if (levels_in_use !== want.levels)
                        report($sformatf("levels_in_use %0d, want %0d",
                                         levels_in_use, want.levels));
                end
            end
        end
    end

    task automatic wait_quiet();
        while (pending_cmds.size() > 0 || start || busy || result_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] s);
        wait_quiet();
        @(negedge clk);
        cfg_we = 1;
        cfg_data = s;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic push_cmd(logic o, logic [63:0] k);
        cmd_t c;
        c.op = o;
        c.key = k;
        pending_cmds.push_back(c);
        if (o == OP_INSERT)
            key_pool.push_back(k);
    endtask

    task automatic add_random(int n);
        int          sel;
        logic [63:0] k;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 9);
            k = {$urandom, $urandom};
            if (key_pool.size() > 0 && sel < 4)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (key_pool.size() > 0 && sel < 6)
                k[31:0] = key_pool[$urandom_range(0, key_pool.size() - 1)][31:0];
            push_cmd(1'($urandom_range(0, 1)), k);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        op = 0;
        key = 0;
        cfg_we = 0;
        cfg_data = 0;
        seed_sh = 0;
        levels_sh = 1;
        for (int i = 0; i < N_SLOTS; i++)
            slot_valid_sh[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_seed(32'h0);
        // same low word in every key: one bucket chain grows to the cap, then full
        for (int i = 0; i < 13; i++)
            push_cmd(OP_INSERT, {32'(i), 32'hdeadbeef});
        push_cmd(OP_INSERT, {32'd3, 32'hdeadbeef});
        push_cmd(OP_QUERY, {32'd5, 32'hdeadbeef});
        push_cmd(OP_QUERY, {32'd20, 32'hdeadbeef});
        push_cmd(OP_QUERY, 64'h0);
        push_cmd(OP_INSERT, 64'h0);
        push_cmd(OP_INSERT, 64'hffff_ffff_ffff_ffff);
        push_cmd(OP_QUERY, 64'hffff_ffff_ffff_ffff);
        push_cmd(OP_INSERT, 64'h0);
        push_cmd(OP_QUERY, 64'h0);

        write_seed(32'hffff_ffff);
        add_random(350);
        write_seed($urandom);
        add_random(350);
        write_seed(32'h1234_5678);
        idle_on = 0;
        add_random(330);

        wait_quiet();
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule
